// File: rtl/audio_ring_pointer_engine_unit_defines.svh
// Assertion macros shared by the ring pointer engine RTL.
`ifndef AUDIO_RING_POINTER_ENGINE_UNIT_DEFINES_SVH
`define AUDIO_RING_POINTER_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ARPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ring pointer engine check failed");

// Next-cycle implication, checked out of reset.
`define ARPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring pointer engine sequence check failed");

`endif

// File: rtl/arpe_pkg.sv
// Types and constants of the ring pointer engine.
package arpe_pkg;

    // Fixed limits of the ring and of one packet.
    localparam int unsigned RING_MAX_BYTES   = 65536;
    localparam int unsigned PACKET_MAX_BYTES = 4096;
    localparam int unsigned RING_CAP_BYTES   =
        (RING_MAX_BYTES < 65536) ? RING_MAX_BYTES : 65536;

    // Error count hysteresis thresholds.
    localparam logic [7:0] STALL_SET_ABOVE   = 8'd32;
    localparam logic [7:0] STALL_CLEAR_BELOW = 8'd8;
    localparam logic [7:0] ERR_COUNT_MAX     = 8'd255;

    // Register indexes on the configuration port.
    localparam logic REG_RING_BYTES   = 1'b0;
    localparam logic REG_PERIOD_BYTES = 1'b1;

    typedef enum logic [1:0] {
        OP_PACKET = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [12:0] packet_len;
        logic        stream_running;
        logic        requeue_failed;
    } t_in_item;

    typedef struct packed {
        logic [15:0] src_offset;
        logic [12:0] dst_offset;
        logic [12:0] seg_len;
        logic        last;
        logic        period_elapsed;
        logic        stalled_now;
    } t_out_item;

    typedef struct packed {
        logic [16:0] ring_bytes;
        logic [16:0] period_bytes;
    } t_cfg;

endpackage

// File: rtl/arpe_cfg.sv
// APB-style configuration registers of the ring pointer engine.
module arpe_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output arpe_pkg::t_cfg o_cfg
);
    import arpe_pkg::*;

    logic [16:0] r_ring_bytes;
    logic [16:0] r_period_bytes;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes; the word index is bit 2 of the byte address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_bytes   <= 17'd65536;
            r_period_bytes <= 17'd4096;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_RING_BYTES:   r_ring_bytes   <= pwdata[16:0];
                REG_PERIOD_BYTES: r_period_bytes <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (paddr[2])
            REG_RING_BYTES:   prdata = {15'd0, r_ring_bytes};
            REG_PERIOD_BYTES: prdata = {15'd0, r_period_bytes};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg.ring_bytes   = r_ring_bytes;
    assign o_cfg.period_bytes = r_period_bytes;

endmodule

// File: rtl/arpe_rem.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
module arpe_rem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [16:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_rem
);
    logic [15:0] r_dvd;
    logic [16:0] r_dvs;
    logic [15:0] r_rem;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] trial;
    logic [16:0] diff;
    logic [15:0] n_rem;

    // One shift and trial subtract.
    always_comb begin
        trial = {r_rem, r_dvd[15]};
        diff  = trial - r_dvs;
        n_rem = (trial >= r_dvs) ? diff[15:0] : trial[15:0];
    end

    // Step counter and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[14:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/audio_ring_pointer_engine_unit.sv
// Top level of the ring pointer engine: sequencer, state and output register.
//
//  Channel   Direction  Handshake               Beat
//  in        input      i_in_valid / o_in_stall  t_in_item
//  out       output     o_out_valid / i_out_stall t_out_item
//  cfg       input      psel / penable / pready  32-bit register write
//
// A command or a completion without copy goes straight to the final beat; a completion with copy
// passes CALC1, CALC2 and DIV, and SEG1 too when it wraps into two beats, waiting in DIV on the 16-step
// remainder of the new pointer by the period in the remainder unit.
// Synchronous active-low reset clears pointer, flags and error count.
// One item is handled at a time; output stalls hold the sequencer in its emit state.
module audio_ring_pointer_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  arpe_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output arpe_pkg::t_out_item o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import arpe_pkg::*;
    `include "audio_ring_pointer_engine_unit_defines.svh"

    localparam logic [16:0] RING_CAP = 17'(RING_CAP_BYTES);
    localparam logic [12:0] PKT_MAX  = 13'(PACKET_MAX_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC1,
        S_CALC2,
        S_DIV,
        S_SEG1,
        S_LAST
    } t_state;

    t_cfg        cfg;
    t_state      r_state;
    t_in_item    r_item;
    logic        r_copy;
    logic        r_two;
    logic        r_elapsed;
    logic [15:0] r_read_ptr;
    logic [15:0] r_ptr;
    logic [16:0] r_ring;
    logic [16:0] r_period;
    logic [12:0] r_len;
    logic [12:0] r_split;
    logic        r_active;
    logic        r_stall;
    logic [7:0]  r_err;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        in_acc;
    logic        slot_free;
    logic        emit;
    logic        gate;
    logic [7:0]  err_inc;
    logic        stall_upd;
    logic [16:0] ring_c;
    logic [12:0] len_a;
    logic [12:0] len_c;
    logic [15:0] ptr_c;
    logic [16:0] sum;
    logic [16:0] nptr_w;
    logic [16:0] split_w;
    logic        div_start;
    logic        div_done;
    logic [15:0] div_rem;

    arpe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    arpe_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (nptr_w[15:0]),
        .i_divisor  (r_period),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign div_start   = (r_state == S_CALC2);

    // A result beat is loaded whenever an emit state finds the output slot free.
    assign emit = slot_free && ((r_state == S_SEG1) || (r_state == S_LAST));

    // Copy gate and the error count update of a failed requeue.
    always_comb begin
        gate      = r_active && i_in.stream_running && !r_stall;
        err_inc   = (r_err < ERR_COUNT_MAX) ? r_err + 8'd1 : r_err;
        stall_upd = r_stall;
        if (err_inc > STALL_SET_ABOVE) begin
            stall_upd = 1'b1;
        end else if (err_inc < STALL_CLEAR_BELOW) begin
            stall_upd = 1'b0;
        end
    end

    // Clamping of ring size, length and start pointer.
    always_comb begin
        if (cfg.ring_bytes == 17'd0) begin
            ring_c = 17'd1;
        end else if (cfg.ring_bytes > RING_CAP) begin
            ring_c = RING_CAP;
        end else begin
            ring_c = cfg.ring_bytes;
        end
        len_a = (r_item.packet_len > PKT_MAX) ? PKT_MAX : r_item.packet_len;
        len_c = ({4'd0, len_a} > ring_c) ? ring_c[12:0] : len_a;
        ptr_c = ({1'b0, r_read_ptr} >= ring_c) ? 16'd0 : r_read_ptr;
    end

    // Advance of the pointer and the wrap split.
    always_comb begin
        sum     = {1'b0, r_ptr} + {4'd0, r_len};
        nptr_w  = (sum >= r_ring) ? sum - r_ring : sum;
        split_w = r_ring - {1'b0, r_ptr};
    end

    // Sequencer, engine state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_read_ptr  <= '0;
            r_active    <= 1'b0;
            r_stall     <= 1'b0;
            r_err       <= '0;
            r_out_valid <= 1'b0;
            r_copy      <= 1'b0;
            r_two       <= 1'b0;
            r_elapsed   <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item    <= i_in;
                        r_copy    <= 1'b0;
                        r_elapsed <= 1'b0;
                        r_state   <= S_LAST;
                        unique case (i_in.op)
                            OP_START: begin
                                r_active <= 1'b1;
                                r_stall  <= 1'b0;
                                r_err    <= '0;
                            end
                            OP_STOP: begin
                                r_active <= 1'b0;
                            end
                            OP_PACKET: begin
                                if (i_in.requeue_failed) begin
                                    r_err   <= err_inc;
                                    r_stall <= stall_upd;
                                end
                                if (gate) begin
                                    r_copy  <= 1'b1;
                                    r_state <= S_CALC1;
                                end
                            end
                            OP_RSVD: ;
                            default: ;
                        endcase
                    end
                end
                S_CALC1: begin
                    r_ring   <= ring_c;
                    r_len    <= len_c;
                    r_ptr    <= ptr_c;
                    r_period <= (cfg.period_bytes == 17'd0) ? 17'd1 : cfg.period_bytes;
                    r_state  <= S_CALC2;
                end
                S_CALC2: begin
                    r_read_ptr <= nptr_w[15:0];
                    r_two      <= (sum > r_ring);
                    r_split    <= split_w[12:0];
                    r_state    <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_elapsed <= ({3'd0, r_len} > div_rem);
                        r_state   <= r_two ? S_SEG1 : S_LAST;
                    end
                end
                S_SEG1: begin
                    if (slot_free) begin
                        r_out.src_offset     <= r_ptr;
                        r_out.dst_offset     <= '0;
                        r_out.seg_len        <= r_split;
                        r_out.last           <= 1'b0;
                        r_out.period_elapsed <= 1'b0;
                        r_out.stalled_now    <= r_stall;
                        r_state              <= S_LAST;
                    end
                end
                S_LAST: begin
                    if (slot_free) begin
                        r_out.last           <= 1'b1;
                        r_out.period_elapsed <= r_elapsed;
                        r_out.stalled_now    <= r_stall;
                        if (!r_copy) begin
                            r_out.src_offset <= '0;
                            r_out.dst_offset <= '0;
                            r_out.seg_len    <= '0;
                        end else if (r_two) begin
                            r_out.src_offset <= '0;
                            r_out.dst_offset <= r_split;
                            r_out.seg_len    <= r_len - r_split;
                        end else begin
                            r_out.src_offset <= r_ptr;
                            r_out.dst_offset <= '0;
                            r_out.seg_len    <= r_len;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A first segment is always followed by a final beat without a gap.
    `ARPE_ASSERT_NEXT(a_seg_pair, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_out.last, o_out_valid && o_out.last)
    // Period notification only rides on the final beat.
    `ARPE_ASSERT_IMPL(a_period_last, i_clk, i_rst_n, o_out_valid && o_out.period_elapsed, o_out.last)
    // A first segment starts the packet and is never empty.
    `ARPE_ASSERT_IMPL(a_seg1_shape, i_clk, i_rst_n, o_out_valid && !o_out.last, o_out.dst_offset == 13'd0 && o_out.seg_len != 13'd0)
    // The remainder unit returns a value below the period.
    `ARPE_ASSERT_IMPL(a_rem_range, i_clk, i_rst_n, r_state == S_DIV && div_done, {1'b0, div_rem} < r_period)

endmodule

// File: dv/audio_ring_pointer_engine_unit_checker.sv
// Checker for the ring pointer engine: tracks register writes, predicts copy segments, compares.
module audio_ring_pointer_engine_unit_checker
    import arpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int unsigned o_mismatches,
    output int unsigned o_pending,
    output int unsigned o_in_beats,
    output int unsigned o_out_beats,
    output int unsigned o_wrapped_copies,
    output int unsigned o_period_marks,
    output int unsigned o_stalled_beats
);

    // Shadow of the engine state and of its two registers.
    logic [15:0] read_pos;
    logic        engine_on;
    logic        stall_set;
    logic [7:0]  requeue_errs;
    logic [16:0] ring_cfg;
    logic [16:0] period_cfg;

    // Copy segments still owed by the engine, oldest first.
    t_out_item   segments_due[$];

    int unsigned mismatches    = 0;
    int unsigned in_beats      = 0;
    int unsigned out_beats     = 0;
    int unsigned wrapped       = 0;
    int unsigned period_marks  = 0;
    int unsigned stalled_beats = 0;

    initial begin
        o_mismatches     = 0;
        o_pending        = 0;
        o_in_beats       = 0;
        o_out_beats      = 0;
        o_wrapped_copies = 0;
        o_period_marks   = 0;
        o_stalled_beats  = 0;
    end

    // One result beat; the stall flag is always the one left after the item.
    function automatic t_out_item segment(input int unsigned src, input int unsigned dst,
                                          input int unsigned len, input logic fin,
                                          input logic mark);
        t_out_item s;
        s.src_offset     = src[15:0];
        s.dst_offset     = dst[12:0];
        s.seg_len        = len[12:0];
        s.last           = fin;
        s.period_elapsed = mark;
        s.stalled_now    = stall_set;
        return s;
    endfunction

    // A failed requeue raises the saturating count; the stall flag has hysteresis.
    task automatic count_requeue_error();
        if (requeue_errs != ERR_COUNT_MAX) begin
            requeue_errs = requeue_errs + 8'd1;
        end
        if (requeue_errs > STALL_SET_ABOVE) begin
            stall_set = 1'b1;
        end else if (requeue_errs < STALL_CLEAR_BELOW) begin
            stall_set = 1'b0;
        end
    endtask

    // Work out the segments that one accepted item gives and queue them.
    task automatic predict_copy_plan(input t_in_item it);
        int unsigned ring;
        int unsigned period;
        int unsigned len;
        int unsigned ptr;
        int unsigned nptr;
        int unsigned split;
        logic        mark;
        if (it.op == OP_START) begin
            engine_on    = 1'b1;
            stall_set    = 1'b0;
            requeue_errs = '0;
        end else if (it.op == OP_STOP) begin
            engine_on = 1'b0;
        end
        if (it.op != OP_PACKET) begin
            segments_due.push_back(segment(0, 0, 0, 1'b1, 1'b0));
        end else if (!(engine_on && it.stream_running && !stall_set)) begin
            if (it.requeue_failed) begin
                count_requeue_error();
            end
            segments_due.push_back(segment(0, 0, 0, 1'b1, 1'b0));
        end else begin
            // Clamp the ring, the period and the length to what the engine can use.
            ring   = 32'(ring_cfg);
            period = (period_cfg == 17'd0) ? 1 : 32'(period_cfg);
            len    = 32'(it.packet_len);
            if (ring == 0) ring = 1;
            if (ring > RING_CAP_BYTES) ring = RING_CAP_BYTES;
            if (len > PACKET_MAX_BYTES) len = PACKET_MAX_BYTES;
            if (len > ring) len = ring;
            ptr = 32'(read_pos);
            if (ptr >= ring) ptr = 0;
            nptr = ptr + len;
            if (nptr >= ring) nptr = nptr - ring;
            read_pos = nptr[15:0];
            mark = ((nptr % period) < len);
            if (it.requeue_failed) begin
                count_requeue_error();
            end
            // A copy that runs past the end of the ring is split in two.
            if (ptr + len <= ring) begin
                segments_due.push_back(segment(ptr, 0, len, 1'b1, mark));
            end else begin
                split = ring - ptr;
                segments_due.push_back(segment(ptr, 0, split, 1'b0, 1'b0));
                segments_due.push_back(segment(0, split, len - split, 1'b1, mark));
                wrapped++;
            end
            if (mark) period_marks++;
        end
    endtask

    // Compare one result beat with the oldest segment owed.
    task automatic check_segment(input t_out_item got);
        t_out_item want;
        out_beats++;
        if (got.stalled_now === 1'b1) stalled_beats++;
        if (segments_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result beat: src=%0d dst=%0d len=%0d last=%0b per=%0b stl=%0b",
                         got.src_offset, got.dst_offset, got.seg_len, got.last,
                         got.period_elapsed, got.stalled_now);
            end
        end else begin
            want = segments_due.pop_front();
            if (got.src_offset !== want.src_offset || got.dst_offset !== want.dst_offset ||
                got.seg_len !== want.seg_len || got.last !== want.last ||
                got.period_elapsed !== want.period_elapsed ||
                got.stalled_now !== want.stalled_now) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result beat %0d mismatch", out_beats);
                    $display("  expected src=%0d dst=%0d len=%0d last=%0b per=%0b stl=%0b",
                             want.src_offset, want.dst_offset, want.seg_len, want.last,
                             want.period_elapsed, want.stalled_now);
                    $display("  actual   src=%0d dst=%0d len=%0d last=%0b per=%0b stl=%0b",
                             got.src_offset, got.dst_offset, got.seg_len, got.last,
                             got.period_elapsed, got.stalled_now);
                end
            end
        end
    endtask

    // Watch register writes and both channels on every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            read_pos     = '0;
            engine_on    = 1'b0;
            stall_set    = 1'b0;
            requeue_errs = '0;
            ring_cfg     = 17'd65536;
            period_cfg   = 17'd4096;
            segments_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_PERIOD_BYTES) begin
                    period_cfg = i_pwdata[16:0];
                end else begin
                    ring_cfg = i_pwdata[16:0];
                end
            end
            // Results first: a result never belongs to an item taken at the same edge.
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                check_segment(i_out);
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                in_beats++;
                predict_copy_plan(i_in);
            end
        end
        o_pending        <= segments_due.size();
        o_mismatches     <= mismatches;
        o_in_beats       <= in_beats;
        o_out_beats      <= out_beats;
        o_wrapped_copies <= wrapped;
        o_period_marks   <= period_marks;
        o_stalled_beats  <= stalled_beats;
    end

endmodule

// File: dv/audio_ring_pointer_engine_unit_tb.sv
// Top of the ring pointer engine testbench: clock, reset, stimulus, watchdog and verdict.
module audio_ring_pointer_engine_unit_tb;
    import arpe_pkg::*;

    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned WATCHDOG_LIMIT  = 4000;
    localparam int unsigned PHASES          = 10;
    localparam int unsigned BEATS_PER_PHASE = 130;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned in_beats;
    int unsigned out_beats;
    int unsigned wrapped_copies;
    int unsigned period_marks;
    int unsigned stalled_beats;

    // Stimulus control shared with the receiver process.
    logic        steady_in;
    logic        steady_out;
    logic        hold_req;
    logic        hold_seen;
    int unsigned hold_left;
    int unsigned phase_beats;
    int unsigned idle_cycles;
    int unsigned settings_used;

    logic [16:0] ring_plan[PHASES];
    logic [16:0] period_plan[PHASES];

    audio_ring_pointer_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    audio_ring_pointer_engine_unit_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_in             (i_in),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_out            (o_out),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_in_beats       (in_beats),
        .o_out_beats      (out_beats),
        .o_wrapped_copies (wrapped_copies),
        .o_period_marks   (period_marks),
        .o_stalled_beats  (stalled_beats)
    );

    // Clock with a period of 20 units.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Receiver: random stalls, a long hold-off on request, or none at all when steady.
    initial begin
        i_out_stall = 1'b0;
        hold_seen   = 1'b0;
        hold_left   = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !steady_out && ($urandom_range(99) < 31);
            end
        end
    end

    // Watchdog: cycles in which no beat moves on any port.
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("audio_ring_pointer_engine_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one beat, after random idle cycles, and hold it until it is taken.
    task automatic send_beat(input t_in_item it);
        if (!steady_in) begin
            while ($urandom_range(99) < 31) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        phase_beats++;
    endtask

    task automatic send_item(input t_op op, input logic [12:0] len, input logic running,
                             input logic failed);
        t_in_item it;
        it.op             = op;
        it.packet_len     = len;
        it.stream_running = running;
        it.requeue_failed = failed;
        send_beat(it);
    endtask

    // Stop offering and wait until every predicted segment has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic idx, input logic [16:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {15'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [16:0] ring, input logic [16:0] period);
        drain();
        write_reg(REG_RING_BYTES, ring);
        write_reg(REG_PERIOD_BYTES, period);
        settings_used++;
    endtask

    // Packet length mix: empty, full, oversized, tiny and anything in range.
    function automatic logic [12:0] pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 13'd0;
        if (r < 20) return 13'd4096;
        if (r < 30) return 13'($urandom_range(8191, 4097));
        if (r < 45) return 13'($urandom_range(64, 1));
        return 13'($urandom_range(4096));
    endfunction

    // A session: usually a start, then completions with random content and a little
    // noise, sometimes a stop. A storm fails every requeue but those of the noise to drive the stall flag.
    task automatic run_session(input int unsigned n, input logic storm);
        t_in_item it;
        if (storm || $urandom_range(9) != 0) begin
            send_item(OP_START, 13'($urandom_range(8191)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        end
        repeat (n) begin
            if ($urandom_range(99) < 8) begin
                it.op             = t_op'($urandom_range(3));
                it.packet_len     = 13'($urandom_range(8191));
                it.stream_running = 1'($urandom_range(1));
                it.requeue_failed = 1'($urandom_range(1));
                send_beat(it);
            end else begin
                send_item(OP_PACKET, pick_len(), $urandom_range(99) < 92,
                          storm || ($urandom_range(99) < 8));
            end
        end
        if ($urandom_range(1) == 1) begin
            send_item(OP_STOP, 13'($urandom_range(8191)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        steady_in     = 1'b0;
        steady_out    = 1'b0;
        hold_req      = 1'b0;
        phase_beats   = 0;
        settings_used = 0;

        // Settings: reset values, extremes, clamped values and random ones.
        ring_plan[0] = 17'd65536;   period_plan[0] = 17'd4096;
        ring_plan[1] = 17'd4096;    period_plan[1] = 17'd1;
        ring_plan[2] = 17'd131071;  period_plan[2] = 17'd131071;
        ring_plan[3] = 17'd100;     period_plan[3] = 17'd7;
        ring_plan[4] = 17'd1;       period_plan[4] = 17'd0;
        ring_plan[5] = 17'd65536;   period_plan[5] = 17'd65536;
        for (int p = 6; p < PHASES; p++) begin
            ring_plan[p]   = (p % 2 == 0) ? 17'($urandom_range(65536, 4096))
                                          : 17'($urandom_range(131071, 1));
            period_plan[p] = (p % 2 == 0) ? 17'($urandom_range(4096, 1))
                                          : 17'($urandom_range(131071));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: commands while inactive, reserved op, length extremes at reset values.
        send_item(OP_PACKET, 13'd4096, 1'b1, 1'b1);
        send_item(OP_STOP, 13'd0, 1'b0, 1'b0);
        send_item(OP_RSVD, 13'h1fff, 1'b1, 1'b1);
        send_item(OP_START, 13'd0, 1'b0, 1'b0);
        send_item(OP_PACKET, 13'd0, 1'b1, 1'b0);
        send_item(OP_PACKET, 13'd4096, 1'b1, 1'b0);
        send_item(OP_PACKET, 13'h1fff, 1'b1, 1'b0);
        send_item(OP_PACKET, 13'd100, 1'b0, 1'b1);
        send_item(OP_STOP, 13'd0, 1'b0, 1'b0);
        send_item(OP_PACKET, 13'd64, 1'b1, 1'b0);

        // Directed: pointer past a shrunk ring, a split copy, an exact fit.
        apply_setting(17'd5000, 17'd1000);
        send_item(OP_START, 13'd0, 1'b0, 1'b0);
        send_item(OP_PACKET, 13'd4096, 1'b1, 1'b0);
        send_item(OP_PACKET, 13'd4096, 1'b1, 1'b0);
        send_item(OP_PACKET, 13'd1808, 1'b1, 1'b0);
        send_item(OP_PACKET, 13'd1, 1'b1, 1'b0);

        // Directed: zero ring and zero period, both taken as one.
        apply_setting(17'd0, 17'd0);
        send_item(OP_PACKET, 13'd4096, 1'b1, 1'b0);
        send_item(OP_PACKET, 13'd0, 1'b1, 1'b1);

        // Random phases, one per setting.
        for (int p = 0; p < PHASES; p++) begin
            apply_setting(ring_plan[p], period_plan[p]);
            steady_in  = (p == 5);
            steady_out <= (p == 5);
            // The receiver holds off while the sender keeps offering beats.
            if (p == 1) hold_req <= ~hold_req;
            phase_beats = 0;
            // A long storm saturates the error count.
            if (p == 0) run_session(270, 1'b1);
            while (phase_beats < BEATS_PER_PHASE) begin
                if (p == 2 && phase_beats >= BEATS_PER_PHASE / 2 && phase_beats < 1000) begin
                    drain();
                    phase_beats = phase_beats + 1000;
                end
                run_session($urandom_range(40, 4), $urandom_range(9) == 0);
            end
        end

        drain();
        repeat (40) @(posedge i_clk);

        $display("covered %0d input beats and %0d result beats over %0d register settings",
                 in_beats, out_beats, settings_used);
        $display("wrapped copies %0d, period boundaries %0d, results with stall flag set %0d",
                 wrapped_copies, period_marks, stalled_beats);
        if (mismatches == 0 && pending == 0) begin
            $display("audio_ring_pointer_engine_unit regression: pass");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches, pending);
            $display("audio_ring_pointer_engine_unit regression: fail");
        end
        $finish;
    end

endmodule
